### rtl/chained_hash_set_unit_defines.svh
// assertion helpers used by chained_hash_set_unit
`ifndef CHAINED_HASH_SET_UNIT_DEFINES_SVH
`define CHAINED_HASH_SET_UNIT_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define CHS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("chs assertion failed");

// next-cycle implication
`define CHS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("chs assertion failed");

`endif

### rtl/chs_pkg.sv
package chs_pkg;

    localparam int KEY_W      = 32;
    localparam int CFG_W      = 11;
    localparam int CNT_OUT_W  = 13;
    localparam int HASH_SHIFT = 5;   // key * 31 = (key << 5) - key
    localparam int MOD_STEP   = 4;   // remainder bits resolved per cycle

    localparam int DEF_MAX_BUCKETS     = 1024;
    localparam int DEF_NODE_POOL_DEPTH = 4096;

    localparam logic [CFG_W-1:0] BUCKETS_RESET = 11'd1024;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_HRD,
        ST_HCHK,
        ST_NCHK,
        ST_FIN
    } chs_state_t;

endpackage

### rtl/chs_ram.sv
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/chained_hash_set_unit.sv
// Hash set of 32-bit keys in separately chained buckets. Each transaction on
// the s_ channel inserts (s_action = 0) or looks up (s_action = 1) one key and
// gives one result on the m_ channel. The bucket is (key*31 mod 2^32) modulo
// cfg_wdata as last written (0 acts as 1, values above MAX_BUCKETS act as
// MAX_BUCKETS); a changed bucket count does not rehash stored keys. Items are
// handled one at a time: acceptance, the modulo (4 bits per cycle), the bucket
// head read, the chain nodes visited in turn through the single read port of
// the node memory, and a finish step. The next item is accepted while the
// result waits on m_. After reset every head memory entry is cleared in turn,
// and s_ready is low until that is done.
`include "chained_hash_set_unit_defines.svh"

module chained_hash_set_unit #(
    parameter int MAX_BUCKETS     = chs_pkg::DEF_MAX_BUCKETS,
    parameter int NODE_POOL_DEPTH = chs_pkg::DEF_NODE_POOL_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [chs_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [chs_pkg::KEY_W-1:0]     s_key,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_answer,
    output logic                          m_pool_full,
    output logic [chs_pkg::CNT_OUT_W-1:0] m_element_count
);

    import chs_pkg::*;

    localparam int BW      = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW      = NODE_POOL_DEPTH > 1 ? $clog2(NODE_POOL_DEPTH) : 1;
    localparam int CW      = $clog2(NODE_POOL_DEPTH + 1) > 0 ? $clog2(NODE_POOL_DEPTH + 1) : 1;
    localparam int MW      = $clog2(MAX_BUCKETS + 1) > 0 ? $clog2(MAX_BUCKETS + 1) : 1;
    localparam int MOD_CYC = KEY_W / MOD_STEP;
    localparam int MCW     = MOD_CYC > 1 ? $clog2(MOD_CYC) : 1;
    localparam int HEAD_W  = 1 + NW;
    localparam int NODE_W  = KEY_W + HEAD_W;

    chs_state_t state_reg, state_next;

    logic [BW-1:0]     clr_reg;
    logic [CFG_W-1:0]  cfg_reg;
    logic              action_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  hash_reg;
    logic [MW-1:0]     mod_m_reg;
    logic [MW-1:0]     rem_reg;
    logic [MCW-1:0]    mod_cnt_reg;
    logic [BW-1:0]     bucket_reg;
    logic [HEAD_W-1:0] head_reg;
    logic              present_reg;
    logic [CW-1:0]     count_reg;
    logic              m_valid_reg;
    logic              m_answer_reg;
    logic              m_pool_full_reg;
    logic [CNT_OUT_W-1:0] m_count_reg;

    logic [MW-1:0]     m_eff;
    logic [MW-1:0]     rem_acc;
    logic [MW:0]       rem_wide;
    logic [MW-1:0]     rem_step;
    logic [KEY_W-1:0]  hash_in;

    logic              head_we, head_re;
    logic [BW-1:0]     head_waddr;
    logic [HEAD_W-1:0] head_wdata, head_rdata;
    logic              node_we, node_re;
    logic [NW-1:0]     node_raddr;
    logic [NODE_W-1:0] node_wdata, node_rdata;

    logic              key_hit, link_valid, pool_empty_none, ins_new, fin_go;

    chs_ram #(.WIDTH(HEAD_W), .DEPTH(MAX_BUCKETS)) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (bucket_reg),
        .rdata (head_rdata)
    );

    chs_ram #(.WIDTH(NODE_W), .DEPTH(NODE_POOL_DEPTH)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (count_reg[NW-1:0]),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // effective modulus with zero and overrange clamped
    always_comb begin
        if (cfg_reg == '0) begin
            m_eff = MW'(1);
        end else if (32'(cfg_reg) > 32'(MAX_BUCKETS)) begin
            m_eff = MW'(MAX_BUCKETS);
        end else begin
            m_eff = MW'(cfg_reg);
        end
    end

    assign hash_in = {s_key[KEY_W-HASH_SHIFT-1:0], {HASH_SHIFT{1'b0}}} - s_key;

    // restoring remainder, MOD_STEP bits per cycle
    always_comb begin
        rem_acc  = rem_reg;
        rem_wide = '0;
        for (int i = 0; i < MOD_STEP; i++) begin
            rem_wide = {rem_acc, hash_reg[KEY_W-1-i]};
            if (rem_wide >= {1'b0, mod_m_reg}) begin
                rem_wide = rem_wide - {1'b0, mod_m_reg};
            end
            rem_acc = rem_wide[MW-1:0];
        end
        rem_step = rem_acc;
    end

    assign key_hit         = node_rdata[NODE_W-1 -: KEY_W] == key_reg;
    assign link_valid      = node_rdata[NW];
    assign pool_empty_none = count_reg == CW'(NODE_POOL_DEPTH);
    assign ins_new         = (action_reg == ACT_INSERT) && !present_reg && !pool_empty_none;
    assign fin_go          = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == BW'(MAX_BUCKETS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = ST_MOD;
            ST_MOD:   if (mod_cnt_reg == MCW'(MOD_CYC - 1)) state_next = ST_HRD;
            ST_HRD:   state_next = ST_HCHK;
            ST_HCHK:  state_next = head_rdata[NW] ? ST_NCHK : ST_FIN;
            ST_NCHK: begin
                if (key_hit || !link_valid) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:   if (fin_go) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_ready    = state_reg == ST_IDLE;
        head_re    = state_reg == ST_HRD;
        head_we    = (state_reg == ST_CLEAR) || (fin_go && ins_new);
        head_waddr = (state_reg == ST_CLEAR) ? clr_reg : bucket_reg;
        head_wdata = (state_reg == ST_CLEAR) ? '0 : {1'b1, count_reg[NW-1:0]};
        node_we    = fin_go && ins_new;
        node_wdata = {key_reg, head_reg};
        node_re    = ((state_reg == ST_HCHK) && head_rdata[NW])
                  || ((state_reg == ST_NCHK) && !key_hit && link_valid);
        node_raddr = (state_reg == ST_HCHK) ? head_rdata[NW-1:0] : node_rdata[NW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            cfg_reg     <= BUCKETS_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            if (fin_go && ins_new) begin
                count_reg <= count_reg + 1'b1;
            end
            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg  <= s_action;
            key_reg     <= s_key;
            hash_reg    <= hash_in;
            mod_m_reg   <= m_eff;
            rem_reg     <= '0;
            mod_cnt_reg <= '0;
            present_reg <= 1'b0;
        end
        if (state_reg == ST_MOD) begin
            rem_reg     <= rem_step;
            hash_reg    <= hash_reg << MOD_STEP;
            mod_cnt_reg <= mod_cnt_reg + 1'b1;
            bucket_reg  <= rem_step[BW-1:0];
        end
        if (state_reg == ST_HCHK) begin
            head_reg <= head_rdata;
        end
        if (state_reg == ST_NCHK && key_hit) begin
            present_reg <= 1'b1;
        end
        if (fin_go) begin
            m_answer_reg    <= (action_reg == ACT_QUERY) ? present_reg : ins_new;
            m_pool_full_reg <= (action_reg == ACT_INSERT) && !present_reg && pool_empty_none;
            m_count_reg     <= CNT_OUT_W'(ins_new ? count_reg + 1'b1 : count_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_answer        = m_answer_reg;
    assign m_pool_full     = m_pool_full_reg;
    assign m_element_count = m_count_reg;

    `CHS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(NODE_POOL_DEPTH))
    `CHS_ASSERT_IMPL(a_node_read_linked, node_re, CW'(node_raddr) < count_reg)
    `CHS_ASSERT_NEXT(a_accept_starts_mod, s_valid && s_ready, state_reg == ST_MOD)
    `CHS_ASSERT_NEXT(a_insert_counts, fin_go && ins_new, count_reg == CW'($past(count_reg) + 1'b1))

endmodule

### sim/chained_hash_set_unit_test.sv
`timescale 1ns / 1ps

module chained_hash_set_unit_test;

    import chs_pkg::*;

    localparam int BUCKET_MAX  = DEF_MAX_BUCKETS;
    localparam int POOL_DEPTH  = DEF_NODE_POOL_DEPTH;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic                 answer;
        logic                 pool_full;
        logic [CNT_OUT_W-1:0] element_count;
    } set_reply_t;

    typedef struct {
        logic        action;
        logic [31:0] key;
        logic        typed;
        set_reply_t  reply;
    } set_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = ACT_INSERT;
    logic [KEY_W-1:0]     s_key = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_answer;
    logic                 m_pool_full;
    logic [CNT_OUT_W-1:0] m_element_count;

    // tag travelling with the payload: typed expectation for directed rows
    logic       row_typed = 1'b0;
    set_reply_t row_reply = '0;

    // shadow copy of the set
    logic [CFG_W-1:0] shadow_buckets = BUCKETS_RESET;
    logic             head_ok   [BUCKET_MAX];
    int unsigned      head_idx  [BUCKET_MAX];
    logic [31:0]      node_key  [POOL_DEPTH];
    logic             link_ok   [POOL_DEPTH];
    int unsigned      link_idx  [POOL_DEPTH];
    int unsigned      shadow_count = 0;

    set_reply_t  pending_replies[$];
    logic [31:0] seen_keys[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          n_insert = 0, n_query = 0, n_full = 0, n_replies = 0;
    bit          calm = 0;

    chained_hash_set_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_key           (s_key),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_answer        (m_answer),
        .m_pool_full     (m_pool_full),
        .m_element_count (m_element_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic set_reply_t hash_set_apply(logic act, logic [31:0] key);
        int unsigned modulus;
        logic [31:0] hashed;
        int unsigned bkt, n, steps;
        logic        ok, found;
        set_reply_t  r;
        modulus = shadow_buckets;
        if (modulus == 0) modulus = 1;
        if (modulus > BUCKET_MAX) modulus = BUCKET_MAX;
        hashed = key * 32'd31;
        bkt = hashed % modulus;
        ok = head_ok[bkt];
        n = head_idx[bkt];
        steps = 0;
        found = 1'b0;
        while (ok && !found && steps < POOL_DEPTH) begin
            if (node_key[n] == key) found = 1'b1;
            ok = link_ok[n];
            n = link_idx[n];
            steps++;
        end
        r = '0;
        if (act == ACT_QUERY) begin
            r.answer = found;
        end else if (!found) begin
            if (shadow_count >= POOL_DEPTH) begin
                r.pool_full = 1'b1;
            end else begin
                node_key[shadow_count] = key;
                link_ok[shadow_count] = head_ok[bkt];
                link_idx[shadow_count] = head_idx[bkt];
                head_ok[bkt] = 1'b1;
                head_idx[bkt] = shadow_count;
                shadow_count++;
                r.answer = 1'b1;
            end
        end
        r.element_count = shadow_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    // prediction at acceptance, checking of results, ready stalls, watchdog
    always @(posedge aclk) begin
        set_reply_t want, got;
        if (aresetn) begin
            if (cfg_we) shadow_buckets = cfg_wdata;
            if (s_valid && s_ready) begin
                want = hash_set_apply(s_action, s_key);
                if (row_typed) want = row_reply;
                pending_replies.push_back(want);
                if (s_action == ACT_QUERY) n_query++; else n_insert++;
            end
            if (m_valid && m_ready) begin
                got = '{m_answer, m_pool_full, m_element_count};
                n_replies++;
                if (got.pool_full) n_full++;
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected transaction, answer %0d full %0d count %0d",
                             $time, got.answer, got.pool_full, got.element_count);
                    errors++;
                end else begin
                    want = pending_replies.pop_front();
                    if (got.answer !== want.answer) begin
                        $display("%0t: answer expected %0d actual %0d",
                                 $time, want.answer, got.answer);
                        errors++;
                    end
                    if (got.pool_full !== want.pool_full) begin
                        $display("%0t: pool_full expected %0d actual %0d",
                                 $time, want.pool_full, got.pool_full);
                        errors++;
                    end
                    if (got.element_count !== want.element_count) begin
                        $display("%0t: element_count expected %0d actual %0d",
                                 $time, want.element_count, got.element_count);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic act, logic [31:0] key, logic typed, set_reply_t reply);
        int gap;
        s_valid <= 1'b1;
        s_action <= act;
        s_key <= key;
        row_typed <= typed;
        row_reply <= reply;
        do @(posedge aclk); while (!s_ready);
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 35)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(int unsigned insert_pct);
        logic [31:0] key;
        logic        act;
        if (seen_keys.size() > 0 && $urandom_range(0, 99) < 45)
            key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        else begin
            key = $urandom;
            if (seen_keys.size() < 512) seen_keys.push_back(key);
            else seen_keys[$urandom_range(0, 511)] = key;
        end
        act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_QUERY;
        send_item(act, key, 1'b0, '0);
    endtask

    task automatic settle_and_configure(logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    set_row_t directed_rows[] = '{
        '{ACT_QUERY,  32'h0000_0000, 1'b1, '{1'b0, 1'b0, 13'd0}},
        '{ACT_INSERT, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 13'd1}},
        '{ACT_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 13'd1}},
        '{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 13'd2}},
        '{ACT_QUERY,  32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 13'd2}},
        '{ACT_QUERY,  32'h0000_0001, 1'b1, '{1'b0, 1'b0, 13'd2}},
        '{ACT_INSERT, 32'h8000_0000, 1'b1, '{1'b1, 1'b0, 13'd3}},
        '{ACT_INSERT, 32'h0000_0400, 1'b1, '{1'b1, 1'b0, 13'd4}},
        '{ACT_QUERY,  32'h0000_0400, 1'b1, '{1'b1, 1'b0, 13'd4}},
        '{ACT_QUERY,  32'h0000_0000, 1'b1, '{1'b1, 1'b0, 13'd4}},
        '{ACT_INSERT, 32'h5555_5555, 1'b1, '{1'b1, 1'b0, 13'd5}},
        '{ACT_INSERT, 32'hAAAA_AAAA, 1'b1, '{1'b1, 1'b0, 13'd6}},
        '{ACT_QUERY,  32'h5555_5555, 1'b1, '{1'b1, 1'b0, 13'd6}},
        '{ACT_QUERY,  32'hAAAA_AAAA, 1'b1, '{1'b1, 1'b0, 13'd6}},
        '{ACT_INSERT, 32'h0000_0400, 1'b1, '{1'b0, 1'b0, 13'd6}},
        '{ACT_QUERY,  32'h0000_0800, 1'b1, '{1'b0, 1'b0, 13'd6}}
    };

    logic [CFG_W-1:0] phase_buckets[] = '{11'd0, 11'd1, 11'd2047, 11'd1024, 11'd7,
                                          11'd1000, 11'd33, 11'd512};

    initial begin
        foreach (head_ok[i]) begin
            head_ok[i] = 1'b0;
            head_idx[i] = 0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].action, directed_rows[i].key,
                      directed_rows[i].typed, directed_rows[i].reply);

        // small moduli make long chains, so those phases stay short
        foreach (phase_buckets[p]) begin
            settle_and_configure(phase_buckets[p]);
            calm = (p == 3);
            repeat (phase_buckets[p] < 3 ? 30 : 200) send_random(55);
        end
        calm = 0;
        settle_and_configure(CFG_W'($urandom_range(3, 2047)));
        repeat (150) send_random(50);

        // insert-heavy traffic at the full bucket count
        settle_and_configure(11'd1024);
        repeat (180) send_random(70);

        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d inserts and %0d lookups over %0d bucket settings",
                 n_insert, n_query, phase_buckets.size() + 3);
        $display("%0d results checked, %0d refused for a full pool", n_replies, n_full);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### chained_hash_set_unit.f
+incdir+rtl
rtl/chs_pkg.sv
rtl/chs_ram.sv
rtl/chained_hash_set_unit.sv
sim/chained_hash_set_unit_test.sv
